// File: rtl/pvm_pkg.sv
// ----------------------------------------------------------------------------
// pvm_pkg
// Shared sizes, types and address helpers of the paged translation unit.
// ----------------------------------------------------------------------------
package pvm_pkg;

   localparam int OFFSET_BITS    = 4;
   localparam int VIRT_ADDR_BITS = 12;
   localparam int FRAME_COUNT    = 16;
   localparam int LEVELS         = 2;

   localparam int DATA_BITS  = 32;
   localparam int PA_BITS    = 8;
   localparam int PAGE_WORDS = 1 << OFFSET_BITS;
   localparam int MEM_WORDS  = FRAME_COUNT * PAGE_WORDS;
   localparam int PAGE_BITS  = VIRT_ADDR_BITS - OFFSET_BITS;
   localparam int PAGE_COUNT = 1 << PAGE_BITS;
   localparam int DIST_BITS  = PAGE_BITS + 1;
   localparam int FRAME_BITS = $clog2(FRAME_COUNT);
   localparam int MEM_ABITS  = $clog2(MEM_WORDS);
   localparam int SD_BITS    = $clog2(LEVELS + 1);
   localparam int LVL_BITS   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ROOT_BITS  = (VIRT_ADDR_BITS > LEVELS * OFFSET_BITS) ?
                               (VIRT_ADDR_BITS - LEVELS * OFFSET_BITS) : 0;

   typedef logic [FRAME_BITS-1:0]     frame_type;
   typedef logic [MEM_ABITS-1:0]      maddr_type;
   typedef logic [PAGE_BITS-1:0]      page_type;
   typedef logic [OFFSET_BITS-1:0]    row_type;
   typedef logic [SD_BITS-1:0]        depth_type;
   typedef logic [VIRT_ADDR_BITS-1:0] vaddr_type;
   typedef logic [DIST_BITS-1:0]      dist_type;

   localparam row_type ROW_LAST = OFFSET_BITS'(PAGE_WORDS - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_WALK_RD, S_WALK_CHK, S_SCAN_ENTER, S_SCAN_RD, S_SCAN_CHK,
      S_SCAN_NEXT, S_PICK, S_FOUND_NF, S_FOUND_CLR, S_EVICT_NF, S_EVICT_RD,
      S_EVICT_WR, S_EVICT_CLR, S_CHECK_NF, S_FILL, S_RESTORE_RD, S_RESTORE_WR,
      S_ZERO, S_LINK, S_ACCESS, S_ACCESS_RD, S_DROP, S_RESPOND
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_WALK_RD, OP_WALK_NEXT, OP_SCAN_INIT, OP_SCAN_ENTER,
      OP_SCAN_RD, OP_SCAN_DESCEND, OP_ROW_NEXT, OP_LEVEL_UP, OP_SET_FOUND,
      OP_UNLINK_RD, OP_TAKE_NF, OP_FREE_NF, OP_UNLINK_CLR, OP_EVICT_RD,
      OP_EVICT_WR, OP_RESTORE_RD, OP_RESTORE_WR, OP_ZERO_WR, OP_LINK,
      OP_ACCESS, OP_ACCESS_RES, OP_DROP, OP_RESPOND
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic entry_zero;
      logic walk_last;
      logic scan_leaf;
      logic row_last;
      logic level_top;
      logic level_unlinkable;
      logic found;
      logic have_free;
      logic far_is_target;
      logic nf_zero;
      logic swap_hit;
      logic copy_last;
      logic func_write;
      logic rsp_free;
   } status_type;

   // Word address of entry idx in frame f, wrapped to the frame memory size.
   function automatic maddr_type frame_addr(frame_type f, vaddr_type idx);
      maddr_type base;
      base = MEM_ABITS'({f, {OFFSET_BITS{1'b0}}});
      return base + MEM_ABITS'(idx);
   endfunction

   // Table index used at walk level d.
   function automatic vaddr_type walk_index(vaddr_type va, depth_type d);
      int        right;
      int        size;
      vaddr_type mask;
      right = (LEVELS - int'(d)) * OFFSET_BITS;
      size  = (d == '0) ? ROOT_BITS : OFFSET_BITS;
      mask  = VIRT_ADDR_BITS'((64'(1) << size) - 64'(1));
      return (va >> right) & mask;
   endfunction

   // Page number reached through row of a table at scan depth sd.
   function automatic page_type child_page(page_type page, row_type row, depth_type sd);
      int          shift;
      logic [63:0] tmp;
      shift = (LEVELS - 1 - int'(sd)) * OFFSET_BITS;
      tmp   = 64'(row) << shift;
      return page + PAGE_BITS'(tmp);
   endfunction

   function automatic dist_type cyc_dist(page_type a, page_type b);
      dist_type d;
      dist_type e;
      d = (a > b) ? {1'b0, page_type'(a - b)} : {1'b0, page_type'(b - a)};
      e = DIST_BITS'(PAGE_COUNT) - d;
      return (d < e) ? d : e;
   endfunction

endpackage

// File: rtl/pvm_ctrl.sv
// ----------------------------------------------------------------------------
// pvm_ctrl
// Sequencer of the walk, the frame scan, the page copies and the response.
// ----------------------------------------------------------------------------
module pvm_ctrl import pvm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_WALK_RD;
         end
         S_WALK_RD: state_in = S_WALK_CHK;
         S_WALK_CHK: begin
            if (!status.entry_zero) begin
               state_in = status.walk_last ? S_ACCESS : S_WALK_RD;
            end else begin
               state_in = S_SCAN_ENTER;
            end
         end
         S_SCAN_ENTER: state_in = status.scan_leaf ? S_SCAN_NEXT : S_SCAN_RD;
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: state_in = status.entry_zero ? S_SCAN_NEXT : S_SCAN_ENTER;
         S_SCAN_NEXT: begin
            priority if (!status.row_last) state_in = S_SCAN_RD;
            else if (status.level_unlinkable) state_in = S_PICK;
            else if (status.level_top) state_in = S_PICK;
            else state_in = S_SCAN_NEXT;
         end
         S_PICK: begin
            priority if (status.found) state_in = S_FOUND_NF;
            else if (status.have_free) state_in = S_FILL;
            else if (status.far_is_target) state_in = S_DROP;
            else state_in = S_EVICT_NF;
         end
         S_FOUND_NF: state_in = S_FOUND_CLR;
         S_FOUND_CLR: state_in = S_CHECK_NF;
         S_EVICT_NF: state_in = S_EVICT_RD;
         S_EVICT_RD: state_in = S_EVICT_WR;
         S_EVICT_WR: state_in = status.copy_last ? S_EVICT_CLR : S_EVICT_RD;
         S_EVICT_CLR: state_in = S_CHECK_NF;
         S_CHECK_NF: state_in = status.nf_zero ? S_DROP : S_FILL;
         S_FILL: begin
            priority if (status.walk_last) begin
               state_in = status.swap_hit ? S_RESTORE_RD : S_LINK;
            end else if (!status.found) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_LINK;
            end
         end
         S_RESTORE_RD: state_in = S_RESTORE_WR;
         S_RESTORE_WR: state_in = status.copy_last ? S_LINK : S_RESTORE_RD;
         S_ZERO: state_in = status.copy_last ? S_LINK : S_ZERO;
         S_LINK: state_in = status.walk_last ? S_ACCESS : S_WALK_RD;
         S_ACCESS: state_in = status.func_write ? S_RESPOND : S_ACCESS_RD;
         S_ACCESS_RD: state_in = S_RESPOND;
         S_DROP: state_in = S_RESPOND;
         S_RESPOND: begin
            if (status.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = OP_NONE;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) cmd.op = OP_ACCEPT;
         end
         S_WALK_RD: cmd.op = OP_WALK_RD;
         S_WALK_CHK: cmd.op = status.entry_zero ? OP_SCAN_INIT : OP_WALK_NEXT;
         S_SCAN_ENTER: cmd.op = OP_SCAN_ENTER;
         S_SCAN_RD: cmd.op = OP_SCAN_RD;
         S_SCAN_CHK: cmd.op = status.entry_zero ? OP_NONE : OP_SCAN_DESCEND;
         S_SCAN_NEXT: begin
            priority if (!status.row_last) cmd.op = OP_ROW_NEXT;
            else if (status.level_unlinkable) cmd.op = OP_SET_FOUND;
            else if (status.level_top) cmd.op = OP_NONE;
            else cmd.op = OP_LEVEL_UP;
         end
         S_PICK: begin
            priority if (status.found) cmd.op = OP_UNLINK_RD;
            else if (status.have_free) cmd.op = OP_FREE_NF;
            else if (status.far_is_target) cmd.op = OP_NONE;
            else cmd.op = OP_UNLINK_RD;
         end
         S_FOUND_NF: cmd.op = OP_TAKE_NF;
         S_FOUND_CLR: cmd.op = OP_UNLINK_CLR;
         S_EVICT_NF: cmd.op = OP_TAKE_NF;
         S_EVICT_RD: cmd.op = OP_EVICT_RD;
         S_EVICT_WR: cmd.op = OP_EVICT_WR;
         S_EVICT_CLR: cmd.op = OP_UNLINK_CLR;
         S_CHECK_NF: cmd.op = OP_NONE;
         S_FILL: cmd.op = OP_NONE;
         S_RESTORE_RD: cmd.op = OP_RESTORE_RD;
         S_RESTORE_WR: cmd.op = OP_RESTORE_WR;
         S_ZERO: cmd.op = OP_ZERO_WR;
         S_LINK: cmd.op = OP_LINK;
         S_ACCESS: cmd.op = OP_ACCESS;
         S_ACCESS_RD: cmd.op = OP_ACCESS_RES;
         S_DROP: cmd.op = OP_DROP;
         S_RESPOND: begin
            if (status.rsp_free) cmd.op = OP_RESPOND;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

endmodule

// File: rtl/pvm_datapath.sv
// ----------------------------------------------------------------------------
// pvm_datapath
// Frame memory, swap store, scan stack and result register of the unit.
// ----------------------------------------------------------------------------
module pvm_datapath import pvm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic                        req_func,
   input  logic [VIRT_ADDR_BITS-1:0]   req_virtual_address,
   input  logic signed [DATA_BITS-1:0] req_write_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DATA_BITS-1:0] rsp_read_value,
   output logic [PA_BITS-1:0]          rsp_physical_address
);

   // Memories.
   logic [DATA_BITS-1:0] frame_mem [MEM_WORDS];
   logic [DATA_BITS-1:0] swap_mem  [PAGE_COUNT * PAGE_WORDS];
   logic [MEM_WORDS-1:0] frame_vld_ff;
   logic [DATA_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic [DATA_BITS-1:0] swap_data_ff;

   logic                 mem_we, mem_re, swap_we, swap_re;
   maddr_type            mem_addr;
   logic [DATA_BITS-1:0] mem_wdata, swap_wdata;
   vaddr_type            swap_addr;

   // Registers.
   logic                 func_ff, func_in;
   vaddr_type            va_ff, va_in;
   logic [DATA_BITS-1:0] wv_ff, wv_in;
   depth_type            d_ff, d_in;
   frame_type            cur_ff, cur_in;
   maddr_type            ea_ff, ea_in;
   frame_type            max_ff, max_in;
   page_type             far_ff, far_in;
   maddr_type            unlink_ff, unlink_in;
   logic                 found_ff, found_in;
   frame_type            nd_frame_ff, nd_frame_in;
   maddr_type            nd_from_ff, nd_from_in;
   page_type             nd_page_ff, nd_page_in;
   depth_type            sd_ff, sd_in;
   frame_type            stk_frame_ff [LEVELS];
   frame_type            stk_frame_in [LEVELS];
   row_type              stk_row_ff [LEVELS];
   row_type              stk_row_in [LEVELS];
   maddr_type            stk_from_ff [LEVELS];
   maddr_type            stk_from_in [LEVELS];
   page_type             stk_page_ff [LEVELS];
   page_type             stk_page_in [LEVELS];
   logic                 stk_empty_ff [LEVELS];
   logic                 stk_empty_in [LEVELS];
   frame_type            nf_ff, nf_in;
   row_type              cnt_ff, cnt_in;
   logic [DATA_BITS-1:0] res_ff, res_in;
   maddr_type            pa_ff, pa_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [PA_BITS-1:0]   rsp_pa_ff, rsp_pa_in;
   logic [PAGE_COUNT-1:0] swap_valid_ff, swap_valid_in;

   logic [DATA_BITS-1:0] rd_word;
   page_type             target;
   logic [LVL_BITS-1:0]  lvl;
   maddr_type            walk_addr, scan_addr, copy_addr, access_addr;

   // A frame memory word never written reads as zero.
   assign rd_word     = rd_vld_ff ? rd_data_ff : '0;
   assign target      = va_ff[VIRT_ADDR_BITS-1 -: PAGE_BITS];
   assign lvl         = sd_ff[LVL_BITS-1:0];
   assign walk_addr   = frame_addr(cur_ff, walk_index(va_ff, d_ff));
   assign scan_addr   = frame_addr(stk_frame_ff[lvl], VIRT_ADDR_BITS'(stk_row_ff[lvl]));
   assign copy_addr   = frame_addr(nf_ff, VIRT_ADDR_BITS'(cnt_ff));
   assign access_addr = frame_addr(cur_ff, VIRT_ADDR_BITS'(va_ff[OFFSET_BITS-1:0]));

   always_comb begin
      func_in       = func_ff;
      va_in         = va_ff;
      wv_in         = wv_ff;
      d_in          = d_ff;
      cur_in        = cur_ff;
      ea_in         = ea_ff;
      max_in        = max_ff;
      far_in        = far_ff;
      unlink_in     = unlink_ff;
      found_in      = found_ff;
      nd_frame_in   = nd_frame_ff;
      nd_from_in    = nd_from_ff;
      nd_page_in    = nd_page_ff;
      sd_in         = sd_ff;
      stk_frame_in  = stk_frame_ff;
      stk_row_in    = stk_row_ff;
      stk_from_in   = stk_from_ff;
      stk_page_in   = stk_page_ff;
      stk_empty_in  = stk_empty_ff;
      nf_in         = nf_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      pa_in         = pa_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_pa_in     = rsp_pa_ff;
      swap_valid_in = swap_valid_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = '0;
      mem_wdata     = '0;
      swap_we       = 1'b0;
      swap_re       = 1'b0;
      swap_addr     = '0;
      swap_wdata    = '0;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_ACCEPT: begin
            func_in = req_func;
            va_in   = req_virtual_address;
            wv_in   = req_write_value;
            d_in    = '0;
            cur_in  = '0;
         end
         OP_WALK_RD: begin
            mem_re   = 1'b1;
            mem_addr = walk_addr;
            ea_in    = walk_addr;
         end
         OP_WALK_NEXT: begin
            cur_in = rd_word[FRAME_BITS-1:0];
            d_in   = d_ff + 1'b1;
         end
         OP_SCAN_INIT: begin
            max_in      = '0;
            far_in      = target;
            unlink_in   = '0;
            found_in    = 1'b0;
            nd_frame_in = '0;
            nd_from_in  = '0;
            nd_page_in  = '0;
            sd_in       = '0;
         end
         OP_SCAN_ENTER: begin
            if (nd_frame_ff > max_ff) max_in = nd_frame_ff;
            if (sd_ff < SD_BITS'(LEVELS)) begin
               stk_frame_in[lvl] = nd_frame_ff;
               stk_row_in[lvl]   = '0;
               stk_from_in[lvl]  = nd_from_ff;
               stk_page_in[lvl]  = nd_page_ff;
               stk_empty_in[lvl] = 1'b1;
            end else begin
               // Leaf page: keep the farthest one, first met wins a tie.
               if (cyc_dist(nd_page_ff, target) > cyc_dist(far_ff, target)) begin
                  far_in    = nd_page_ff;
                  unlink_in = nd_from_ff;
               end
               sd_in = SD_BITS'(LEVELS - 1);
            end
         end
         OP_SCAN_RD: begin
            mem_re   = 1'b1;
            mem_addr = scan_addr;
         end
         OP_SCAN_DESCEND: begin
            stk_empty_in[lvl] = 1'b0;
            nd_frame_in       = rd_word[FRAME_BITS-1:0];
            nd_from_in        = scan_addr;
            nd_page_in        = child_page(stk_page_ff[lvl], stk_row_ff[lvl], sd_ff);
            sd_in             = sd_ff + 1'b1;
         end
         OP_ROW_NEXT: begin
            stk_row_in[lvl] = stk_row_ff[lvl] + 1'b1;
         end
         OP_LEVEL_UP: begin
            sd_in = sd_ff - 1'b1;
         end
         OP_SET_FOUND: begin
            found_in  = 1'b1;
            unlink_in = stk_from_ff[lvl];
         end
         OP_UNLINK_RD: begin
            mem_re   = 1'b1;
            mem_addr = unlink_ff;
         end
         OP_TAKE_NF: begin
            nf_in  = rd_word[FRAME_BITS-1:0];
            cnt_in = '0;
         end
         OP_FREE_NF: begin
            nf_in  = max_ff + 1'b1;
            cnt_in = '0;
         end
         OP_UNLINK_CLR: begin
            mem_we   = 1'b1;
            mem_addr = unlink_ff;
         end
         OP_EVICT_RD: begin
            mem_re   = 1'b1;
            mem_addr = copy_addr;
         end
         OP_EVICT_WR: begin
            swap_we    = 1'b1;
            swap_addr  = {far_ff, cnt_ff};
            swap_wdata = rd_word;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == ROW_LAST) swap_valid_in[far_ff] = 1'b1;
         end
         OP_RESTORE_RD: begin
            swap_re   = 1'b1;
            swap_addr = {target, cnt_ff};
         end
         OP_RESTORE_WR: begin
            mem_we    = 1'b1;
            mem_addr  = copy_addr;
            mem_wdata = swap_data_ff;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == ROW_LAST) swap_valid_in[target] = 1'b0;
         end
         OP_ZERO_WR: begin
            mem_we   = 1'b1;
            mem_addr = copy_addr;
            cnt_in   = cnt_ff + 1'b1;
         end
         OP_LINK: begin
            mem_we    = 1'b1;
            mem_addr  = ea_ff;
            mem_wdata = DATA_BITS'(nf_ff);
            cur_in    = nf_ff;
            d_in      = d_ff + 1'b1;
         end
         OP_ACCESS: begin
            pa_in    = access_addr;
            mem_addr = access_addr;
            if (func_ff) begin
               mem_we    = 1'b1;
               mem_wdata = wv_ff;
               res_in    = wv_ff;
            end else begin
               mem_re = 1'b1;
            end
         end
         OP_ACCESS_RES: begin
            res_in = rd_word;
         end
         OP_DROP: begin
            res_in = '0;
            pa_in  = '0;
         end
         OP_RESPOND: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = res_ff;
            rsp_pa_in    = PA_BITS'(pa_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status.entry_zero       = (rd_word == '0);
      status.walk_last        = (d_ff == SD_BITS'(LEVELS - 1));
      status.scan_leaf        = (sd_ff == SD_BITS'(LEVELS));
      status.row_last         = (stk_row_ff[lvl] == ROW_LAST);
      status.level_top        = (sd_ff == '0);
      status.level_unlinkable = stk_empty_ff[lvl] && (stk_frame_ff[lvl] != cur_ff);
      status.found            = found_ff;
      status.have_free        = (max_ff != FRAME_BITS'(FRAME_COUNT - 1));
      status.far_is_target    = (far_ff == target);
      status.nf_zero          = (nf_ff == '0);
      status.swap_hit         = swap_valid_ff[target];
      status.copy_last        = (cnt_ff == ROW_LAST);
      status.func_write       = func_ff;
      status.rsp_free         = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         swap_valid_ff <= '0;
         frame_vld_ff  <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         swap_valid_ff <= swap_valid_in;
         if (mem_we) frame_vld_ff[mem_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      va_ff        <= va_in;
      wv_ff        <= wv_in;
      d_ff         <= d_in;
      cur_ff       <= cur_in;
      ea_ff        <= ea_in;
      max_ff       <= max_in;
      far_ff       <= far_in;
      unlink_ff    <= unlink_in;
      found_ff     <= found_in;
      nd_frame_ff  <= nd_frame_in;
      nd_from_ff   <= nd_from_in;
      nd_page_ff   <= nd_page_in;
      sd_ff        <= sd_in;
      stk_frame_ff <= stk_frame_in;
      stk_row_ff   <= stk_row_in;
      stk_from_ff  <= stk_from_in;
      stk_page_ff  <= stk_page_in;
      stk_empty_ff <= stk_empty_in;
      nf_ff        <= nf_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
      pa_ff        <= pa_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pa_ff    <= rsp_pa_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) frame_mem[mem_addr] <= mem_wdata;
      if (mem_re) begin
         rd_data_ff <= frame_mem[mem_addr];
         rd_vld_ff  <= frame_vld_ff[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (swap_we) swap_mem[swap_addr] <= swap_wdata;
      if (swap_re) swap_data_ff <= swap_mem[swap_addr];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_value       = rsp_value_ff;
   assign rsp_physical_address = rsp_pa_ff;

endmodule

// File: rtl/paged_vm_translation_with_eviction_unit.sv
// ----------------------------------------------------------------------------
// paged_vm_translation_with_eviction_unit
// Multi-level page table walk over a frame memory, with frame allocation,
// table reuse and page eviction to a swap store on a missing entry.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transaction
//   req_      in         func, virtual_address, write_value
//   rsp_      out        read_value, physical_address
//
// With all entries present, a transaction reads and checks one entry per
// table level, then performs the final access and the response. A missing
// entry starts a depth-first scan of the page table tree through the single
// frame memory port, followed where needed by a word-by-word page eviction,
// restore or table zeroing.
// Reset clears the state machine, the frame memory valid bits and the swap
// valid bits at once; no clearing pass is needed. Requests are stalled while
// a transaction is in progress; a finished result waits in the output
// register under rsp_stall while the next request is already accepted.
//
module paged_vm_translation_with_eviction_unit import pvm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [VIRT_ADDR_BITS-1:0]   req_virtual_address,
   input  logic signed [DATA_BITS-1:0] req_write_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DATA_BITS-1:0] rsp_read_value,
   output logic [PA_BITS-1:0]          rsp_physical_address
);

   cmd_type    cmd;
   status_type status;

   // The controller sequences the walk and the scan; the datapath holds the
   // memories, the scan stack and the result register.
   pvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pvm_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_func             (req_func),
      .req_virtual_address  (req_virtual_address),
      .req_write_value      (req_write_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_read_value       (rsp_read_value),
      .rsp_physical_address (rsp_physical_address)
   );

endmodule

// File: tb/paged_vm_translation_with_eviction_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paged_vm_translation_with_eviction_unit_test
// Self-checking testbench: a queue-fed driver sends reads and writes, a
// software page table walker predicts every response, and a monitor compares.
// ----------------------------------------------------------------------------
module paged_vm_translation_with_eviction_unit_test;
   import pvm_pkg::*;

   // Operation codes of one transaction.
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef struct {
      logic                 func;
      logic [11:0]          va;
      logic signed [31:0]   wv;
   } access_type;

   typedef struct {
      logic signed [31:0]   rv;
      logic [7:0]           pa;
   } outcome_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_func;
   logic [VIRT_ADDR_BITS-1:0] req_virtual_address;
   logic signed [DATA_BITS-1:0] req_write_value;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [DATA_BITS-1:0] rsp_read_value;
   logic [PA_BITS-1:0] rsp_physical_address;

   paged_vm_translation_with_eviction_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_virtual_address(req_virtual_address), .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_read_value(rsp_read_value), .rsp_physical_address(rsp_physical_address)
   );

   // Shadow copy of the block's memories; the swap store is only read where
   // its page mark is set, so it needs no reset value.
   logic [31:0] frames [MEM_WORDS];
   logic [31:0] swap_words [PAGE_COUNT * PAGE_WORDS];
   logic        swap_marked [PAGE_COUNT];

   // Scan results of one frame search.
   int unsigned hi_frame, far_page, unlink_addr, scan_origin, scan_target;
   bit          empty_found;

   access_type  pending_access [$];
   outcome_type expected_outcome [$];
   int          errors;
   bit          stimulus_done;

   function automatic int unsigned page_distance(int unsigned a, int unsigned b);
      int unsigned d, e;
      d = (a > b) ? a - b : b - a;
      e = PAGE_COUNT - d;
      return (d < e) ? d : e;
   endfunction

   // Depth-first walk of the table tree in row order.
   function automatic void tree_scan(int unsigned frame, int unsigned depth,
                                     int unsigned from, int unsigned page);
      bit          empty;
      int unsigned shift, row, addr, entry, child;
      if (frame > hi_frame) hi_frame = frame;
      if (depth < LEVELS) begin
         empty = 1;
         shift = (LEVELS - 1 - depth) * OFFSET_BITS;
         for (row = 0; row < PAGE_WORDS; row++) begin
            addr  = (frame * PAGE_WORDS + row) % MEM_WORDS;
            entry = frames[addr];
            if (entry != 0) begin
               child = (page + (row << shift)) % PAGE_COUNT;
               empty = 0;
               tree_scan(entry % FRAME_COUNT, depth + 1, addr, child);
               if (empty_found) return;
            end
         end
         if (empty && frame != scan_origin) begin
            empty_found = 1;
            unlink_addr = from;
         end
      end else if (page_distance(page, scan_target) > page_distance(far_page, scan_target)) begin
         far_page    = page;
         unlink_addr = from;
      end
   endfunction

   // Picks a frame for a missing entry; returns 0 when the access is dropped.
   function automatic bit allocate_frame(int unsigned origin, int unsigned depth,
                                         int unsigned target, output int unsigned nf);
      int unsigned i;
      hi_frame = 0; far_page = target; unlink_addr = 0;
      empty_found = 0; scan_origin = origin; scan_target = target;
      tree_scan(0, 0, 0, 0);
      if (empty_found) begin
         nf = frames[unlink_addr] % FRAME_COUNT;
         frames[unlink_addr] = 0;
      end else if (hi_frame < FRAME_COUNT - 1) begin
         nf = hi_frame + 1;
      end else begin
         if (far_page == target) return 0;
         nf = frames[unlink_addr] % FRAME_COUNT;
         for (i = 0; i < PAGE_WORDS; i++)
            swap_words[far_page * PAGE_WORDS + i] = frames[(nf * PAGE_WORDS + i) % MEM_WORDS];
         swap_marked[far_page] = 1;
         frames[unlink_addr] = 0;
      end
      if (nf == 0) return 0;
      if (depth == LEVELS - 1) begin
         if (swap_marked[target]) begin
            for (i = 0; i < PAGE_WORDS; i++)
               frames[nf * PAGE_WORDS + i] = swap_words[target * PAGE_WORDS + i];
            swap_marked[target] = 0;
         end
      end else if (!empty_found) begin
         for (i = 0; i < PAGE_WORDS; i++) frames[nf * PAGE_WORDS + i] = 0;
      end
      return 1;
   endfunction

   function automatic outcome_type translate_access(access_type a);
      outcome_type o;
      int unsigned cur, d, right, size, idx, ea, entry, nf, target, pa;
      target = (a.va >> OFFSET_BITS) % PAGE_COUNT;
      cur = 0;
      for (d = 0; d < LEVELS; d++) begin
         right = (LEVELS - d) * OFFSET_BITS;
         size  = (d == 0) ? ROOT_BITS : OFFSET_BITS;
         idx   = (a.va >> right) & ((1 << size) - 1);
         ea    = (cur * PAGE_WORDS + idx) % MEM_WORDS;
         entry = frames[ea];
         if (entry == 0) begin
            if (!allocate_frame(cur, d, target, nf)) begin
               o.rv = 0; o.pa = 0;
               return o;
            end
            frames[ea] = nf;
            entry = nf;
         end
         cur = entry % FRAME_COUNT;
      end
      pa = (cur * PAGE_WORDS + (a.va & (PAGE_WORDS - 1))) % MEM_WORDS;
      if (a.func == FUNC_WRITE) begin
         frames[pa] = a.wv;
         o.rv = a.wv;
      end else begin
         o.rv = frames[pa];
      end
      o.pa = pa[7:0];
      return o;
   endfunction

   // Gap length: usually zero or short, now and then long.
   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void queue_access(logic func, logic [11:0] va, logic [31:0] wv);
      access_type a;
      a.func = func; a.va = va; a.wv = wv;
      pending_access.push_back(a);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      int n, p, k;
      logic [11:0] va;
      reset = 1;
      foreach (frames[i]) frames[i] = 0;
      foreach (swap_marked[i]) swap_marked[i] = 0;
      // Directed: field extremes, both operations, write then read back.
      queue_access(FUNC_READ, 12'h000, 32'h0);
      queue_access(FUNC_WRITE, 12'h000, 32'h7FFF_FFFF);
      queue_access(FUNC_READ, 12'h000, 32'hFFFF_FFFF);
      queue_access(FUNC_WRITE, 12'hFFF, 32'h8000_0000);
      queue_access(FUNC_READ, 12'hFFF, 32'h0);
      queue_access(FUNC_WRITE, 12'hAAA, 32'hAAAA_5555);
      queue_access(FUNC_WRITE, 12'h555, 32'h5555_AAAA);
      queue_access(FUNC_READ, 12'hAAA, 32'h0);
      queue_access(FUNC_READ, 12'h555, 32'h0);
      // Touch many pages so frames run out: evictions, swap restores and
      // dropped accesses follow.
      for (p = 0; p < 16; p++)
         queue_access(FUNC_WRITE, {p[3:0], 4'h3, 4'h7}, $urandom);
      queue_access(FUNC_READ, 12'h037, 32'h0);
      queue_access(FUNC_READ, 12'h137, 32'h0);
      // Random: mostly a working set of a few pages, so hits and restores
      // both occur, mixed with scattered addresses.
      for (n = 0; n < 600; n++) begin
         k = $urandom_range(0, 9);
         if (k < 6) va = {$urandom_range(0, 2) == 0 ? 4'hF : 4'h1,
                          4'($urandom_range(0, 5)), 4'($urandom)};
         else va = 12'($urandom);
         queue_access(1'($urandom), va, $urandom);
      end
      stimulus_done = 1;
   end

   // Driver: holds a transaction until accepted, then waits a random gap.
   int unsigned send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_func <= FUNC_READ;
         req_virtual_address <= '0;
         req_write_value <= '0;
         send_gap <= 0;
      end else if (req_valid && !req_stall) begin
         // The accepted transaction is predicted now.
         expected_outcome.push_back(translate_access(pending_access.pop_front()));
         req_valid <= 0;
         send_gap <= gap_length();
      end else if (!req_valid) begin
         if (send_gap != 0) send_gap <= send_gap - 1;
         else if (pending_access.size() != 0) begin
            req_valid <= 1;
            req_func <= pending_access[0].func;
            req_virtual_address <= pending_access[0].va;
            req_write_value <= pending_access[0].wv;
         end
      end
   end

   // Monitor: random response stalls, compare each response with the oldest
   // prediction.
   int unsigned stall_left;
   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcome.size() == 0) begin
               $error("response with no transaction outstanding");
               errors++;
            end else begin
               e = expected_outcome.pop_front();
               if (rsp_read_value !== e.rv) begin
                  $error("read_value expected %h actual %h", e.rv, rsp_read_value);
                  errors++;
               end
               if (rsp_physical_address !== e.pa) begin
                  $error("physical_address expected %h actual %h", e.pa,
                         rsp_physical_address);
                  errors++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= gap_length();
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   initial errors = 0;

   // Hold reset, then wait for the queues to drain.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      wait (stimulus_done && pending_access.size() == 0 && !req_valid
            && expected_outcome.size() == 0);
      repeat (500) @(posedge clock);
      if (errors == 0 && expected_outcome.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Timeout: about 650 transactions, each at most two full tree scans plus
   // page copies and stalls, taken several times over.
   initial begin
      #100_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
